// ----- rtl/vga_command_dirty_tracker_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the VGA command dirty tracker
// Clocked on aclk; the module using them must have aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef VGA_COMMAND_DIRTY_TRACKER_TOP_MACROS_SVH
`define VGA_COMMAND_DIRTY_TRACKER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define VCT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked on every edge, reset included.
`define VCT_ASSERT_RESET(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define VCT_ASSERT(label, prop, msg)
`define VCT_ASSERT_RESET(label, prop, msg)
`endif

`endif

// ----- rtl/vct_pkg.sv -----
// ----------------------------------------------------------------------------
// vct_pkg
// Shared types, opcodes and constants of the VGA command dirty tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vct_pkg;

    // Command opcodes
    localparam logic [2:0] OP_SET_MODE     = 3'd0;
    localparam logic [2:0] OP_GET_MODE     = 3'd1;
    localparam logic [2:0] OP_PAL_WRITE    = 3'd2;
    localparam logic [2:0] OP_PAL_READ     = 3'd3;
    localparam logic [2:0] OP_DIRTY_RECT   = 3'd4;
    localparam logic [2:0] OP_CURSOR_MOVE  = 3'd5;
    localparam logic [2:0] OP_CURSOR_SHAPE = 3'd6;
    localparam logic [2:0] OP_GET_DIRTY    = 3'd7;

    // Merge operand select
    localparam logic [2:0] MSEL_SCREEN_NEW = 3'd0;
    localparam logic [2:0] MSEL_SCREEN     = 3'd1;
    localparam logic [2:0] MSEL_RECT       = 3'd2;
    localparam logic [2:0] MSEL_CUR_OLD    = 3'd3;
    localparam logic [2:0] MSEL_CUR_NEW    = 3'd4;

    // Mode reset values and text mode signatures
    localparam logic [15:0] RESET_WIDTH     = 16'd640;
    localparam logic [15:0] RESET_HEIGHT    = 16'd480;
    localparam logic [7:0]  RESET_DEPTH     = 8'd8;
    localparam logic [15:0] TEXT_WIDE_W     = 16'd720;
    localparam logic [15:0] TEXT_WIDE_H     = 16'd400;
    localparam logic [7:0]  TEXT_WIDE_DEPTH = 8'd4;
    localparam logic [15:0] TEXT_NARROW_W   = 16'd640;
    localparam logic [15:0] TEXT_NARROW_H   = 16'd200;

    // Character cell size in pixels
    localparam logic [15:0] CELL_W = 16'd8;
    localparam logic [15:0] CELL_H = 16'd16;

    // Entries preloaded with the standard colors
    localparam logic [8:0] STD_COLOR_COUNT = 9'd16;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] size_w;
        logic [15:0] size_h;
        logic [7:0]  depth_bits;
        logic [31:0] row_pitch;
        logic [7:0]  pal_index;
        logic [5:0]  red;
        logic [5:0]  green;
        logic [5:0]  blue;
        logic        cursor_on;
    } in_t;

    typedef struct packed {
        logic        dirty_flag;
        logic [15:0] out_x;
        logic [15:0] out_y;
        logic [15:0] out_w;
        logic [15:0] out_h;
        logic [7:0]  out_depth;
        logic        out_graphics;
        logic [31:0] out_pitch;
        logic [23:0] out_color;
    } out_t;

    // Controller to datapath
    typedef struct packed {
        logic       capture;
        logic       set_mode;
        logic       pal_write;
        logic       pal_read;
        logic       cursor_move;
        logic       cursor_shape;
        logic       merge_en;
        logic [2:0] merge_sel;
        logic       rem_en;
        logic       load_out;
        logic       clear_dirty;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [2:0] op;
        logic [2:0] held_op;
        logic       cursor_marks;
        logic       out_free;
    } sts_t;

    function automatic logic [23:0] std_color(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'h000000;
            4'd1:    c = 24'h0000AA;
            4'd2:    c = 24'h00AA00;
            4'd3:    c = 24'h00AAAA;
            4'd4:    c = 24'hAA0000;
            4'd5:    c = 24'hAA00AA;
            4'd6:    c = 24'hAA5500;
            4'd7:    c = 24'hAAAAAA;
            4'd8:    c = 24'h555555;
            4'd9:    c = 24'h5555FF;
            4'd10:   c = 24'h55FF55;
            4'd11:   c = 24'h55FFFF;
            4'd12:   c = 24'hFF5555;
            4'd13:   c = 24'hFF55FF;
            4'd14:   c = 24'hFFFF55;
            default: c = 24'hFFFFFF;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vga_command_dirty_tracker_top.sv -----
// ----------------------------------------------------------------------------
// VGA command dirty tracker
// Takes one guest display command per transfer and returns exactly one
// result transfer for it. The block holds the mode (size, depth, pitch,
// text/graphics), the cursor cell and visibility, a palette memory and one
// pending dirty bounding box merged by union in 16-bit arithmetic; get-dirty
// reads and clears the box. A command is applied at the edge of its input
// transfer and its result is loaded into the output register in the done
// step that follows. A cursor move in text mode with the cursor shown
// first runs the cursor cell steps: one step forms the old cell's column
// from the registered quotient, then the old and new 8x16 cells go one
// after the other through the single merge unit, then the result is
// loaded. The input is taken only while the sequencer is idle; a finished
// result may still wait in the output register while the next command is
// taken, but the sequencer holds in its load step while an earlier result
// is still unread, so output stalls hold up the next command. No clearing
// pass runs after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module vga_command_dirty_tracker_top #(
    parameter int PALETTE_ENTRIES = 256,   // 16 to 256
    parameter int TEXT_COLUMNS    = 80     // 1 to 255
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  vct_pkg::in_t    s_data,

    output logic            m_valid,
    input  wire logic       m_ready,
    output vct_pkg::out_t   m_data
);

    // Sequencer commands and datapath status
    vct_pkg::cmd_t cmd;
    vct_pkg::sts_t sts;

    // Controller: accept, cursor cell steps, result load
    vct_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // Datapath: state registers, palette memory, merge unit, result register
    vct_datapath #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES),
        .TEXT_COLUMNS    (TEXT_COLUMNS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .sts     (sts),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

// ----- rtl/vct_ctrl.sv -----
// ----------------------------------------------------------------------------
// vct_ctrl
// Command sequencer: applies a command on its transfer, runs the cursor
// cell steps, then loads the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vga_command_dirty_tracker_top_macros.svh"

module vct_ctrl (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  vct_pkg::sts_t      sts,
    output vct_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_CUR_REM = 3'd1;
    localparam logic [2:0] ST_CUR_OLD = 3'd2;
    localparam logic [2:0] ST_CUR_NEW = 3'd3;
    localparam logic [2:0] ST_DONE    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DONE;
                    unique case (sts.op)
                        vct_pkg::OP_SET_MODE: begin
                            cmd.set_mode  = 1'b1;
                            cmd.merge_en  = 1'b1;
                            cmd.merge_sel = vct_pkg::MSEL_SCREEN_NEW;
                        end
                        vct_pkg::OP_PAL_WRITE: begin
                            cmd.pal_write = 1'b1;
                            cmd.merge_en  = 1'b1;
                            cmd.merge_sel = vct_pkg::MSEL_SCREEN;
                        end
                        vct_pkg::OP_PAL_READ: begin
                            cmd.pal_read = 1'b1;
                        end
                        vct_pkg::OP_DIRTY_RECT: begin
                            cmd.merge_en  = 1'b1;
                            cmd.merge_sel = vct_pkg::MSEL_RECT;
                        end
                        vct_pkg::OP_CURSOR_MOVE: begin
                            cmd.cursor_move = 1'b1;
                            if (sts.cursor_marks) begin
                                state_next = ST_CUR_REM;
                            end
                        end
                        vct_pkg::OP_CURSOR_SHAPE: begin
                            cmd.cursor_shape = 1'b1;
                        end
                        default: ;  // get mode, get dirty: result only
                    endcase
                end
            end
            ST_CUR_REM: begin
                cmd.rem_en = 1'b1;
                state_next = ST_CUR_OLD;
            end
            ST_CUR_OLD: begin
                cmd.merge_en  = 1'b1;
                cmd.merge_sel = vct_pkg::MSEL_CUR_OLD;
                state_next    = ST_CUR_NEW;
            end
            ST_CUR_NEW: begin
                cmd.merge_en  = 1'b1;
                cmd.merge_sel = vct_pkg::MSEL_CUR_NEW;
                state_next    = ST_DONE;
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.load_out    = 1'b1;
                    cmd.clear_dirty = (sts.held_op == vct_pkg::OP_GET_DIRTY);
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `VCT_ASSERT(a_busy_after_accept, (s_valid && s_ready) |=> !s_ready, "accepted back to back")
    `VCT_ASSERT(a_load_needs_room, cmd.load_out |-> sts.out_free, "result loaded over a held one")
    `VCT_ASSERT(a_capture_on_accept, cmd.capture |-> (s_valid && s_ready), "capture without transfer")

endmodule

`default_nettype wire

// ----- rtl/vct_datapath.sv -----
// ----------------------------------------------------------------------------
// vct_datapath
// Mode, cursor and dirty box registers, palette memory, box merge unit,
// cursor cell divider and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "vga_command_dirty_tracker_top_macros.svh"

module vct_datapath #(
    parameter int PALETTE_ENTRIES = 256,
    parameter int TEXT_COLUMNS    = 80
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  vct_pkg::in_t       s_data,
    input  vct_pkg::cmd_t      cmd,
    output vct_pkg::sts_t      sts,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vct_pkg::out_t      m_data
);

    localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);
    localparam logic [7:0] COLS = 8'(TEXT_COLUMNS);
    // cell / COLS as (cell * RECIP) >> DIV_SHIFT, exact for 16-bit cells
    localparam int DIV_SHIFT = 16 + $clog2(TEXT_COLUMNS);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
        ((64'd1 << DIV_SHIFT) + 64'(TEXT_COLUMNS) - 64'd1) / 64'(TEXT_COLUMNS));

    vct_pkg::in_t  in_reg;

    logic [15:0] mode_width_reg;
    logic [15:0] mode_height_reg;
    logic [7:0]  mode_depth_reg;
    logic [31:0] mode_pitch_reg;
    logic        graphics_reg;
    logic        graphics_next;
    logic [15:0] cursor_cell_reg;
    logic        cursor_shown_reg;
    logic [15:0] old_cell_reg;
    logic [15:0] q_reg;
    logic [7:0]  rem_reg;

    logic        dirty_pending_reg;
    logic [15:0] dirty_left_reg;
    logic [15:0] dirty_top_reg;
    logic [15:0] dirty_width_reg;
    logic [15:0] dirty_height_reg;

    logic [23:0]                pal_mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] pal_valid_reg;
    logic [23:0]                rd_mem_reg;
    logic                       rd_valid_reg;
    logic                       rd_hit_reg;
    logic [7:0]                 rd_idx_reg;

    logic                m_valid_reg;
    vct_pkg::out_t       m_data_reg;
    vct_pkg::out_t       res;

    // ------------------------------------------------------------------
    // Input decode
    // ------------------------------------------------------------------
    logic [PAL_AW-1:0]      pal_addr;
    logic                   pal_in;
    logic [23:0]            pal_color;
    logic [15:0]            new_cell;
    logic [15+RECIP_W:0]    q_prod;
    logic [15:0]            quot;

    assign pal_addr  = s_data.pal_index[PAL_AW-1:0];
    assign pal_in    = ({1'b0, s_data.pal_index} < PAL_LIMIT);
    assign pal_color = {s_data.red, 2'b00, s_data.green, 2'b00, s_data.blue, 2'b00};
    assign new_cell  = 16'(s_data.pos_y * COLS) + s_data.pos_x;
    assign q_prod    = {{RECIP_W{1'b0}}, cursor_cell_reg} * {16'd0, RECIP};
    assign quot      = q_prod[DIV_SHIFT +: 16];

    always_comb begin
        graphics_next = 1'b1;
        if (s_data.size_w == vct_pkg::TEXT_WIDE_W && s_data.size_h == vct_pkg::TEXT_WIDE_H &&
            s_data.depth_bits == vct_pkg::TEXT_WIDE_DEPTH) begin
            graphics_next = 1'b0;
        end else if (s_data.size_w == vct_pkg::TEXT_NARROW_W &&
                     s_data.size_h == vct_pkg::TEXT_NARROW_H) begin
            graphics_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Mode and cursor state
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_width_reg   <= vct_pkg::RESET_WIDTH;
            mode_height_reg  <= vct_pkg::RESET_HEIGHT;
            mode_depth_reg   <= vct_pkg::RESET_DEPTH;
            mode_pitch_reg   <= '0;
            graphics_reg     <= 1'b0;
            cursor_cell_reg  <= '0;
            cursor_shown_reg <= 1'b1;
        end else begin
            if (cmd.set_mode) begin
                mode_width_reg  <= s_data.size_w;
                mode_height_reg <= s_data.size_h;
                mode_depth_reg  <= s_data.depth_bits;
                mode_pitch_reg  <= s_data.row_pitch;
                graphics_reg    <= graphics_next;
            end
            if (cmd.cursor_move) begin
                cursor_cell_reg <= new_cell;
            end
            if (cmd.cursor_shape) begin
                cursor_shown_reg <= s_data.cursor_on;
            end
        end
    end

    // Held command and cursor divider steps
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
        if (cmd.cursor_move) begin
            old_cell_reg <= cursor_cell_reg;
            q_reg        <= quot;
        end
        if (cmd.rem_en) begin
            rem_reg <= 8'(old_cell_reg - 16'(q_reg * COLS));
        end
    end

    // ------------------------------------------------------------------
    // Palette memory; unwritten entries read as their reset color
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (cmd.pal_write && pal_in) begin
            pal_mem[pal_addr] <= pal_color;
        end
        if (cmd.pal_read) begin
            rd_mem_reg <= pal_mem[pal_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_valid_reg <= '0;
        end else if (cmd.pal_write && pal_in) begin
            pal_valid_reg[pal_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pal_read) begin
            rd_valid_reg <= pal_valid_reg[pal_addr];
            rd_hit_reg   <= pal_in;
            rd_idx_reg   <= s_data.pal_index;
        end
    end

    logic [23:0] rd_color;

    always_comb begin
        rd_color = '0;
        if (rd_hit_reg) begin
            if (rd_valid_reg) begin
                rd_color = rd_mem_reg;
            end else if ({1'b0, rd_idx_reg} < vct_pkg::STD_COLOR_COUNT) begin
                rd_color = vct_pkg::std_color(rd_idx_reg[3:0]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Dirty box merge
    // ------------------------------------------------------------------
    logic [15:0] mx, my, mw, mh;
    logic [16:0] r1, r2, b1, b2;
    logic [15:0] right, bottom, left_n, top_n;

    always_comb begin
        mx = '0;
        my = '0;
        mw = '0;
        mh = '0;
        unique case (cmd.merge_sel)
            vct_pkg::MSEL_SCREEN_NEW: begin
                mw = s_data.size_w;
                mh = s_data.size_h;
            end
            vct_pkg::MSEL_SCREEN: begin
                mw = mode_width_reg;
                mh = mode_height_reg;
            end
            vct_pkg::MSEL_RECT: begin
                mx = s_data.pos_x;
                my = s_data.pos_y;
                mw = s_data.size_w;
                mh = s_data.size_h;
            end
            vct_pkg::MSEL_CUR_OLD: begin
                mx = {5'b00000, rem_reg, 3'b000};
                my = {q_reg[11:0], 4'b0000};
                mw = vct_pkg::CELL_W;
                mh = vct_pkg::CELL_H;
            end
            vct_pkg::MSEL_CUR_NEW: begin
                mx = {in_reg.pos_x[12:0], 3'b000};
                my = {in_reg.pos_y[11:0], 4'b0000};
                mw = vct_pkg::CELL_W;
                mh = vct_pkg::CELL_H;
            end
            default: ;
        endcase
    end

    assign r1     = {1'b0, dirty_left_reg} + {1'b0, dirty_width_reg};
    assign r2     = {1'b0, mx} + {1'b0, mw};
    assign b1     = {1'b0, dirty_top_reg} + {1'b0, dirty_height_reg};
    assign b2     = {1'b0, my} + {1'b0, mh};
    assign right  = (r1 > r2) ? r1[15:0] : r2[15:0];
    assign bottom = (b1 > b2) ? b1[15:0] : b2[15:0];
    assign left_n = (mx < dirty_left_reg) ? mx : dirty_left_reg;
    assign top_n  = (my < dirty_top_reg) ? my : dirty_top_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirty_pending_reg <= 1'b0;
            dirty_left_reg    <= '0;
            dirty_top_reg     <= '0;
            dirty_width_reg   <= '0;
            dirty_height_reg  <= '0;
        end else if (cmd.merge_en) begin
            dirty_pending_reg <= 1'b1;
            if (dirty_pending_reg) begin
                dirty_left_reg   <= left_n;
                dirty_top_reg    <= top_n;
                dirty_width_reg  <= right - left_n;
                dirty_height_reg <= bottom - top_n;
            end else begin
                dirty_left_reg   <= mx;
                dirty_top_reg    <= my;
                dirty_width_reg  <= mw;
                dirty_height_reg <= mh;
            end
        end else if (cmd.clear_dirty) begin
            dirty_pending_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    always_comb begin
        res              = '0;
        res.out_graphics = graphics_reg;
        unique case (in_reg.opcode)
            vct_pkg::OP_GET_MODE: begin
                res.out_w     = mode_width_reg;
                res.out_h     = mode_height_reg;
                res.out_depth = mode_depth_reg;
                res.out_pitch = mode_pitch_reg;
            end
            vct_pkg::OP_PAL_READ: begin
                res.out_color = rd_color;
            end
            vct_pkg::OP_GET_DIRTY: begin
                if (dirty_pending_reg) begin
                    res.dirty_flag = 1'b1;
                    res.out_x      = dirty_left_reg;
                    res.out_y      = dirty_top_reg;
                    res.out_w      = dirty_width_reg;
                    res.out_h      = dirty_height_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign sts.op           = s_data.opcode;
    assign sts.held_op      = in_reg.opcode;
    assign sts.cursor_marks = !graphics_reg && cursor_shown_reg;
    assign sts.out_free     = !m_valid_reg || m_ready;

    `VCT_ASSERT(a_merge_sets_pending, cmd.merge_en |=> dirty_pending_reg, "merge left box idle")
    `VCT_ASSERT(a_remainder_range, cmd.rem_en |=> (rem_reg < COLS), "cursor column out of range")
    `VCT_ASSERT(a_result_presented, cmd.load_out |=> m_valid_reg, "loaded result not presented")
    `VCT_ASSERT_RESET(a_reset_clears_out, !aresetn |=> !m_valid_reg, "result valid after reset")

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for the VGA command dirty tracker
// Sends guest display commands over the input channel and predicts every
// result with a local model of the mode, cursor, palette and dirty box
// state. Directed tests cover reset values, mode classification, palette
// extremes, box union with wraparound and cursor cell marking. A long run
// of random commands follows. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam int PAL_ENTRIES     = 256;
    localparam int COLUMN_COUNT    = 80;
    localparam int RANDOM_COMMANDS = 1900;
    // Slowest correct gap between transfers is an input gap plus an output
    // stall plus a marking cursor move; this limit is far longer.
    localparam int STALL_LIMIT     = 2000;
    // Longest command is a cursor move with marking.
    localparam int DRAIN_CYCLES    = 20;

    // Power-up contents of the first 16 palette entries
    localparam logic [23:0] VGA_COLORS [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5500, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    // ------------------------------------------------------------------
    // Clock, reset and DUT
    // ------------------------------------------------------------------
    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    vct_pkg::in_t   s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    vct_pkg::out_t  m_data;

    always #5 aclk = ~aclk;

    vga_command_dirty_tracker_top #(
        .PALETTE_ENTRIES(PAL_ENTRIES),
        .TEXT_COLUMNS   (COLUMN_COUNT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // Local model of the display state
    // ------------------------------------------------------------------
    logic [15:0] mode_w;
    logic [15:0] mode_h;
    logic [7:0]  mode_bpp;
    logic [31:0] mode_stride;
    logic        gfx_mode;
    logic [15:0] cursor_idx;
    logic        cursor_vis;
    logic [23:0] palette [PAL_ENTRIES];
    logic        box_pending;
    logic [15:0] box_x, box_y, box_w, box_h;

    vct_pkg::out_t expected_results [$];

    // Run statistics
    int mismatches     = 0;
    int n_commands     = 0;
    int n_results      = 0;
    int n_cursor_marks = 0;
    int n_box_reads    = 0;

    // When set, neither side idles: valid and ready stay high with no gaps.
    logic steady_flow = 1'b0;

    function automatic void reset_display_state();
        mode_w      = vct_pkg::RESET_WIDTH;
        mode_h      = vct_pkg::RESET_HEIGHT;
        mode_bpp    = vct_pkg::RESET_DEPTH;
        mode_stride = '0;
        gfx_mode    = 1'b0;
        cursor_idx  = '0;
        cursor_vis  = 1'b1;
        for (int i = 0; i < PAL_ENTRIES; i++)
            palette[i] = (i < 16) ? VGA_COLORS[i] : 24'h0;
        box_pending = 1'b0;
        box_x = '0; box_y = '0; box_w = '0; box_h = '0;
    endfunction

    // Union of the pending box with a new area. Edges are 17-bit sums,
    // the resulting size wraps at 16 bits.
    function automatic void union_box(logic [15:0] x, logic [15:0] y,
                                      logic [15:0] w, logic [15:0] h);
        logic [16:0] r_old, r_new, b_old, b_new;
        logic [15:0] right_x, bottom_y;
        if (!box_pending) begin
            box_x = x; box_y = y; box_w = w; box_h = h;
        end else begin
            r_old    = {1'b0, box_x} + {1'b0, box_w};
            r_new    = {1'b0, x} + {1'b0, w};
            b_old    = {1'b0, box_y} + {1'b0, box_h};
            b_new    = {1'b0, y} + {1'b0, h};
            right_x  = (r_old > r_new) ? r_old[15:0] : r_new[15:0];
            bottom_y = (b_old > b_new) ? b_old[15:0] : b_new[15:0];
            if (x < box_x) box_x = x;
            if (y < box_y) box_y = y;
            box_w = right_x - box_x;
            box_h = bottom_y - box_y;
        end
        box_pending = 1'b1;
    endfunction

    // Applies one command to the local state and returns its result.
    function automatic vct_pkg::out_t apply_command(vct_pkg::in_t cmd);
        vct_pkg::out_t res;
        logic [15:0]   prev_cell;
        logic [31:0]   cell_full;
        res = '0;
        case (cmd.opcode)
            vct_pkg::OP_SET_MODE: begin
                mode_w      = cmd.size_w;
                mode_h      = cmd.size_h;
                mode_bpp    = cmd.depth_bits;
                mode_stride = cmd.row_pitch;
                if ((mode_w == vct_pkg::TEXT_WIDE_W && mode_h == vct_pkg::TEXT_WIDE_H &&
                     mode_bpp == vct_pkg::TEXT_WIDE_DEPTH) ||
                    (mode_w == vct_pkg::TEXT_NARROW_W && mode_h == vct_pkg::TEXT_NARROW_H))
                    gfx_mode = 1'b0;
                else
                    gfx_mode = 1'b1;
                union_box(16'd0, 16'd0, mode_w, mode_h);
            end
            vct_pkg::OP_GET_MODE: begin
                res.out_w     = mode_w;
                res.out_h     = mode_h;
                res.out_depth = mode_bpp;
                res.out_pitch = mode_stride;
            end
            vct_pkg::OP_PAL_WRITE: begin
                if (cmd.pal_index < PAL_ENTRIES)
                    palette[cmd.pal_index] = {cmd.red, 2'b00, cmd.green, 2'b00,
                                              cmd.blue, 2'b00};
                // screen goes dirty even for an index past the table
                union_box(16'd0, 16'd0, mode_w, mode_h);
            end
            vct_pkg::OP_PAL_READ: begin
                if (cmd.pal_index < PAL_ENTRIES)
                    res.out_color = palette[cmd.pal_index];
            end
            vct_pkg::OP_DIRTY_RECT: begin
                union_box(cmd.pos_x, cmd.pos_y, cmd.size_w, cmd.size_h);
            end
            vct_pkg::OP_CURSOR_MOVE: begin
                prev_cell  = cursor_idx;
                cell_full  = cmd.pos_y * COLUMN_COUNT + cmd.pos_x;
                cursor_idx = cell_full[15:0];
                if (!gfx_mode && cursor_vis) begin
                    // old cell first, then the new one
                    union_box(16'((prev_cell % COLUMN_COUNT) * 8),
                              16'((prev_cell / COLUMN_COUNT) * 16),
                              vct_pkg::CELL_W, vct_pkg::CELL_H);
                    union_box(16'(cmd.pos_x * 8), 16'(cmd.pos_y * 16),
                              vct_pkg::CELL_W, vct_pkg::CELL_H);
                    n_cursor_marks++;
                end
            end
            vct_pkg::OP_CURSOR_SHAPE: begin
                cursor_vis = cmd.cursor_on;
            end
            vct_pkg::OP_GET_DIRTY: begin
                if (box_pending) begin
                    res.dirty_flag = 1'b1;
                    res.out_x      = box_x;
                    res.out_y      = box_y;
                    res.out_w      = box_w;
                    res.out_h      = box_h;
                    box_pending    = 1'b0;
                    n_box_reads++;
                end
            end
            default: ;
        endcase
        res.out_graphics = gfx_mode;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one command per transfer
    // ------------------------------------------------------------------
    // Valid stays high from one command to the next when no gap is drawn,
    // so s_valid gets a single nonblocking update per edge.
    task automatic send_command(vct_pkg::in_t cmd);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= cmd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        expected_results.push_back(apply_command(cmd));
        n_commands++;
    endtask

    function automatic vct_pkg::in_t blank_command(logic [2:0] op);
        vct_pkg::in_t c;
        c        = '0;
        c.opcode = op;
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Output side: stall at random, compare each result transfer
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    task automatic check_result(vct_pkg::out_t got);
        vct_pkg::out_t want;
        n_results++;
        if (expected_results.size() == 0) begin
            $error("result transfer with no command outstanding");
            mismatches++;
        end else begin
            want = expected_results.pop_front();
            compare_field("dirty_flag",   32'(want.dirty_flag),   32'(got.dirty_flag));
            compare_field("out_x",        32'(want.out_x),        32'(got.out_x));
            compare_field("out_y",        32'(want.out_y),        32'(got.out_y));
            compare_field("out_w",        32'(want.out_w),        32'(got.out_w));
            compare_field("out_h",        32'(want.out_h),        32'(got.out_h));
            compare_field("out_depth",    32'(want.out_depth),    32'(got.out_depth));
            compare_field("out_graphics", 32'(want.out_graphics), 32'(got.out_graphics));
            compare_field("out_pitch",    want.out_pitch,         got.out_pitch);
            compare_field("out_color",    32'(want.out_color),    32'(got.out_color));
        end
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
            check_result(m_data);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on either channel
    // ------------------------------------------------------------------
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("watchdog: no transfer for %0d cycles", idle_cycles);
                $display("vga_command_dirty_tracker_top verification failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------
    // Mode readback, empty box read and palette power-up contents
    task automatic test_reset_values();
        vct_pkg::in_t c;
        send_command(blank_command(vct_pkg::OP_GET_MODE));
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
        foreach (VGA_COLORS[i]) begin
            if (i == 0 || i == 6 || i == 8 || i == 15) begin
                c = blank_command(vct_pkg::OP_PAL_READ);
                c.pal_index = 8'(i);
                send_command(c);
            end
        end
        c = blank_command(vct_pkg::OP_PAL_READ);
        c.pal_index = 8'd16;
        send_command(c);
        c.pal_index = 8'hFF;
        send_command(c);
    endtask

    // Cursor moves in text mode mark old and new cells; hidden cursor marks none
    task automatic test_cursor_marks();
        vct_pkg::in_t c;
        c = blank_command(vct_pkg::OP_CURSOR_MOVE);
        c.pos_x = 16'd79;
        c.pos_y = 16'd24;
        send_command(c);
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
        c = blank_command(vct_pkg::OP_CURSOR_SHAPE);
        c.cursor_on = 1'b0;
        send_command(c);
        c = blank_command(vct_pkg::OP_CURSOR_MOVE);
        c.pos_x = 16'hFFFF;
        c.pos_y = 16'hFFFF;
        send_command(c);
        c = blank_command(vct_pkg::OP_CURSOR_SHAPE);
        c.cursor_on = 1'b1;
        send_command(c);
        // old cell here is the wrapped index left by the extreme move
        send_command(blank_command(vct_pkg::OP_CURSOR_MOVE));
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
    endtask

    // Both text signatures, a near miss, and the widest graphics mode
    task automatic test_mode_switch();
        vct_pkg::in_t c;
        c = blank_command(vct_pkg::OP_SET_MODE);
        c.size_w     = vct_pkg::TEXT_WIDE_W;
        c.size_h     = vct_pkg::TEXT_WIDE_H;
        c.depth_bits = vct_pkg::TEXT_WIDE_DEPTH;
        send_command(c);
        c.depth_bits = 8'd8;
        send_command(c);
        c.size_w     = vct_pkg::TEXT_NARROW_W;
        c.size_h     = vct_pkg::TEXT_NARROW_H;
        c.depth_bits = 8'hFF;
        c.row_pitch  = 32'hFFFF_FFFF;
        send_command(c);
        c.size_w     = 16'hFFFF;
        c.size_h     = 16'hFFFF;
        c.depth_bits = 8'h00;
        c.row_pitch  = 32'h8000_0001;
        send_command(c);
        send_command(blank_command(vct_pkg::OP_GET_MODE));
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
    endtask

    // Full-scale and zero color components, top and bottom entries
    task automatic test_palette_writes();
        vct_pkg::in_t c;
        c = blank_command(vct_pkg::OP_PAL_WRITE);
        c.pal_index = 8'hFF;
        c.red = 6'h3F; c.green = 6'h3F; c.blue = 6'h3F;
        send_command(c);
        c.opcode = vct_pkg::OP_PAL_READ;
        send_command(c);
        c = blank_command(vct_pkg::OP_PAL_WRITE);
        send_command(c);
        c.opcode = vct_pkg::OP_PAL_READ;
        send_command(c);
    endtask

    // Union where both edge sums overflow 16 bits, then an empty area
    task automatic test_box_union();
        vct_pkg::in_t c;
        c = blank_command(vct_pkg::OP_DIRTY_RECT);
        c.pos_x  = 16'hFFFF; c.pos_y  = 16'hFFFF;
        c.size_w = 16'hFFFF; c.size_h = 16'hFFFF;
        send_command(c);
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
        send_command(c);
        c = blank_command(vct_pkg::OP_DIRTY_RECT);
        send_command(c);
        send_command(blank_command(vct_pkg::OP_GET_DIRTY));
    endtask

    // ------------------------------------------------------------------
    // Random traffic
    // ------------------------------------------------------------------
    // Every field starts fully random; the selected command then gets its
    // fields shaped so text modes and on-screen cursor moves come up often.
    function automatic vct_pkg::in_t random_command();
        vct_pkg::in_t c;
        int           pick;
        c.pos_x      = 16'($urandom);
        c.pos_y      = 16'($urandom);
        c.size_w     = 16'($urandom);
        c.size_h     = 16'($urandom);
        c.depth_bits = 8'($urandom);
        c.row_pitch  = $urandom;
        c.pal_index  = 8'($urandom);
        c.red        = 6'($urandom);
        c.green      = 6'($urandom);
        c.blue       = 6'($urandom);
        c.cursor_on  = 1'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            c.opcode = vct_pkg::OP_SET_MODE;
            case ($urandom_range(0, 4))
                0: begin
                    c.size_w = vct_pkg::TEXT_WIDE_W; c.size_h = vct_pkg::TEXT_WIDE_H;
                    c.depth_bits = vct_pkg::TEXT_WIDE_DEPTH;
                end
                1: begin
                    c.size_w = vct_pkg::TEXT_NARROW_W; c.size_h = vct_pkg::TEXT_NARROW_H;
                end
                2: begin
                    c.size_w = vct_pkg::TEXT_WIDE_W; c.size_h = vct_pkg::TEXT_WIDE_H;
                    c.depth_bits = 8'($urandom_range(0, 7));
                end
                3: begin
                    c.size_w = 16'($urandom_range(0, 1023));
                    c.size_h = 16'($urandom_range(0, 1023));
                end
                default: ;
            endcase
        end else if (pick < 14) begin
            c.opcode = vct_pkg::OP_GET_MODE;
        end else if (pick < 26) begin
            c.opcode = vct_pkg::OP_PAL_WRITE;
        end else if (pick < 36) begin
            c.opcode = vct_pkg::OP_PAL_READ;
        end else if (pick < 52) begin
            c.opcode = vct_pkg::OP_DIRTY_RECT;
            if ($urandom_range(0, 1) == 0) begin
                c.pos_x  = 16'($urandom_range(0, 1023));
                c.pos_y  = 16'($urandom_range(0, 1023));
                c.size_w = 16'($urandom_range(0, 255));
                c.size_h = 16'($urandom_range(0, 255));
            end
        end else if (pick < 72) begin
            c.opcode = vct_pkg::OP_CURSOR_MOVE;
            if ($urandom_range(0, 3) != 0) begin
                c.pos_x = 16'($urandom_range(0, COLUMN_COUNT - 1));
                c.pos_y = 16'($urandom_range(0, 24));
            end
        end else if (pick < 80) begin
            c.opcode    = vct_pkg::OP_CURSOR_SHAPE;
            c.cursor_on = ($urandom_range(0, 3) != 0);
        end else begin
            c.opcode = vct_pkg::OP_GET_DIRTY;
        end
        return c;
    endfunction

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_COMMANDS; n++) begin
            // switch between idling and back-to-back stretches
            if (n % 64 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_command(random_command());
        end
        steady_flow = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        reset_display_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_values();
        test_cursor_marks();
        test_mode_switch();
        test_palette_writes();
        test_box_union();
        test_random_traffic();

        // drop valid after the last transfer, then let the results drain
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d commands and compared %0d results.",
                 n_commands, n_results);
        $display("Cursor moves that marked cells: %0d; dirty boxes read back: %0d.",
                 n_cursor_marks, n_box_reads);
        if (mismatches == 0)
            $display("vga_command_dirty_tracker_top verification clean");
        else
            $display("vga_command_dirty_tracker_top verification failed");
        $finish;
    end

endmodule
